[rtl/hll_pkg.sv]
package hll_pkg;

    localparam int PRECISION = 10;
    localparam int M_REGS    = 1 << PRECISION;
    localparam int AW        = PRECISION;
    localparam int CW        = PRECISION + 1;
    localparam int ZW        = PRECISION + 65;
    localparam int KW        = $clog2(PRECISION + 1);
    localparam int LQW       = KW + 32;
    localparam int RANK_W    = 7;
    localparam int EST_SHIFT = 24 - PRECISION;

    localparam logic [63:0] MUR_MUL   = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] MUR_SEED  = 64'h0000_0000_9747_b28c;
    localparam int          MUR_SHIFT = 47;
    localparam logic [31:0] MUL_LO    = MUR_MUL[31:0];
    localparam logic [31:0] MUL_HI    = MUR_MUL[63:32];
    localparam logic [31:0] LN2_Q32   = 32'hB17217F7;
    localparam logic [47:0] EST_MAX   = 48'hFFFF_FFFF_FFFF;

    localparam logic [63:0] M64 = 64'(M_REGS);
    localparam logic [63:0] ALPHA_Q32 =
        (M_REGS == 16) ? (64'd673 << 32) / 64'd1000 :
        (M_REGS == 32) ? (64'd697 << 32) / 64'd1000 :
        (M_REGS == 64) ? (64'd709 << 32) / 64'd1000 :
        (64'd7213 * M64 * 64'd4294967296) / (64'd10000 * M64 + 64'd10790);
    localparam logic [63:0]  ALPHA_MM  = ALPHA_Q32 * M64 * M64;
    localparam logic [127:0] DIV_NUM   = {24'd0, ALPHA_MM, 40'd0};
    localparam logic [63:0]  LIN_LIMIT = 64'd640 * M64;
    localparam logic [LQW-1:0] P_Q32   = {KW'(PRECISION), 32'd0};

    localparam logic FUNC_KEY      = 1'b0;
    localparam logic FUNC_ESTIMATE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [63:0] key_word;
        logic [15:0] key_length;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [47:0] estimate;
        logic        used_linear_count;
        logic [10:0] empty_count;
    } t_out_item;

endpackage

[rtl/hll_in_if.sv]
interface hll_in_if;
    import hll_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/hll_out_if.sv]
interface hll_out_if;
    import hll_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/hll_ram.sv]
module hll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/hll_mul32.sv]
module hll_mul32 (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

[rtl/hll_cardinality_estimator_core.sv]
// Channel  Dir  Payload                                   Transfer
// i_in     in   func, key_word, key_length, last_word     valid & ready
// o_out    out  estimate, used_linear_count, empty_count  valid & ready
//
// One shared 32x32 multiplier does every product; a 64-bit multiply is built from three partial
// products. An estimate is a register walk and a 128-step divide, plus 32 squaring steps for
// the logarithm with linear counting. After reset a clearing pass zeroes every register of the
// rank memory before the first transfer is taken. The result waits in an output register; a
// stalled output holds the next estimate back in S_EMIT, where no input is taken.
module hll_cardinality_estimator_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hll_in_if.sink    i_in,
    hll_out_if.source o_out
);
    import hll_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MUL, S_SEED, S_DISPATCH, S_K1, S_K2, S_HDONE, S_F2,
        S_RANK_RD, S_RANK_WR, S_SUM, S_DIV, S_DECIDE, S_LOG_SQ, S_LOG_UPD,
        S_LN_A, S_LN_B, S_LN_C, S_EMIT
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [1:0]    r_mstep, n_mstep;
    logic [63:0]   r_ma, n_ma, r_p0, n_p0, r_mres, n_mres;
    logic [31:0]   r_psum, n_psum;
    logic [63:0]   r_word, n_word;
    logic [15:0]   r_len, n_len;
    logic          r_last, n_last;
    logic [63:0]   r_h, n_h, r_acc, n_acc;
    logic          r_kip, n_kip;
    logic [CW-1:0] r_addr, n_addr, r_empt, n_empt;
    logic          r_rdv, n_rdv;
    logic [ZW-1:0] r_z, n_z;
    logic [ZW-1:0] r_rem, n_rem;
    logic [127:0]  r_q, n_q, r_num, n_num;
    logic [6:0]    r_cnt, n_cnt;
    logic [31:0]   r_y, n_y, r_frac, n_frac;
    logic [KW-1:0] r_k, n_k;
    logic [63:0]   r_pa, n_pa;
    logic [RANK_W-1:0] r_rank, n_rank;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    t_out_item     r_res, n_res;

    logic [31:0]   c_ma, c_mb;
    logic [63:0]   mul_p;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RANK_W-1:0] ram_wdata, ram_rdata;

    logic [63:0]   c_w, c_mask, c_k1;
    logic [5:0]    c_wpos;
    logic [RANK_W-1:0] c_rank, c_rsat;
    logic [2:0]    c_tail, c_tneg;
    logic [ZW-1:0] c_zadd;
    logic [ZW:0]   c_rem2;
    logic [KW-1:0] c_k;
    logic [32:0]   c_t;
    logic [LQW-1:0] c_lg, c_lq;
    logic [64:0]   c_sum, c_est;
    logic          c_lin;

    hll_mul32 u_mul (
        .i_clk (i_clk),
        .i_a   (c_ma),
        .i_b   (c_mb),
        .o_p   (mul_p)
    );

    hll_ram #(.WIDTH(RANK_W), .DEPTH(M_REGS)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Rank of the finished hash: leading zeros plus one of the bits below the index.
    always_comb begin
        c_w    = r_h << PRECISION;
        c_wpos = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (c_w[i]) begin
                c_wpos = 6'(i);
            end
        end
        c_rank = (c_w == 64'd0) ? RANK_W'(64) : RANK_W'(7'd64 - {1'b0, c_wpos});
    end

    always_comb begin
        c_k = '0;
        for (int i = 0; i < CW; i++) begin
            if (r_empt[i]) begin
                c_k = KW'(i);
            end
        end
    end

    always_comb begin
        c_tail = r_len[2:0];
        c_tneg = 3'd0 - c_tail;
        c_mask = 64'hFFFF_FFFF_FFFF_FFFF >> {c_tneg, 3'b000};
        c_k1   = r_mres ^ (r_mres >> MUR_SHIFT);
        c_rsat = (ram_rdata > RANK_W'(64)) ? RANK_W'(64) : ram_rdata;
        c_zadd = (ram_rdata == '0) ? (ZW'(1) << 64) : (ZW'(1) << (7'd64 - c_rsat));
        c_rem2 = {r_rem, r_num[127]};
        c_t    = mul_p[63:31];
        c_lg   = {r_k, r_frac};
        c_lq   = (c_lg > P_Q32) ? '0 : (P_Q32 - c_lg);
        c_sum  = {1'b0, mul_p} + 65'(r_pa[63:32]);
        c_est  = c_sum >> EST_SHIFT;
        c_lin  = (r_empt != '0) && (r_q[127:64] == 64'd0) && (r_q[63:0] <= LIN_LIMIT);
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;     n_mstep = r_mstep;
        n_ma = r_ma;        n_p0 = r_p0;       n_mres = r_mres;   n_psum = r_psum;
        n_word = r_word;    n_len = r_len;     n_last = r_last;
        n_h = r_h;          n_acc = r_acc;     n_kip = r_kip;
        n_addr = r_addr;    n_empt = r_empt;   n_rdv = r_rdv;     n_z = r_z;
        n_rem = r_rem;      n_q = r_q;         n_num = r_num;     n_cnt = r_cnt;
        n_y = r_y;          n_frac = r_frac;   n_k = r_k;         n_pa = r_pa;
        n_rank = r_rank;    n_out = r_out;     n_res = r_res;
        n_out_valid = r_out_valid & ~o_out.ready;
        c_ma = 32'd0;       c_mb = 32'd0;
        ram_we = 1'b0;      ram_waddr = r_addr[AW-1:0];
        ram_wdata = '0;     ram_raddr = r_addr[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr[AW-1:0] == {AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.data.func == FUNC_KEY) begin
                        n_word = i_in.data.key_word;
                        n_len  = i_in.data.key_length;
                        n_last = i_in.data.last_word;
                        if (r_kip) begin
                            n_h     = r_acc;
                            n_state = S_DISPATCH;
                        end else begin
                            n_ma    = 64'(i_in.data.key_length);
                            n_mstep = 2'd0;
                            n_ret   = S_SEED;
                            n_state = S_MUL;
                        end
                    end else begin
                        n_addr  = '0;
                        n_rdv   = 1'b0;
                        n_z     = '0;
                        n_empt  = '0;
                        n_state = S_SUM;
                    end
                end
            end
            // Low 64 bits of r_ma times the hash constant from three partial products.
            S_MUL: begin
                n_mstep = r_mstep + 1'b1;
                case (r_mstep)
                    2'd0: begin
                        c_ma = r_ma[31:0];  c_mb = MUL_LO;
                    end
                    2'd1: begin
                        c_ma = r_ma[63:32]; c_mb = MUL_LO;
                        n_p0 = mul_p;
                    end
                    2'd2: begin
                        c_ma = r_ma[31:0];  c_mb = MUL_HI;
                        n_psum = mul_p[31:0];
                    end
                    default: begin
                        n_mres  = r_p0 + {r_psum + mul_p[31:0], 32'd0};
                        n_state = r_ret;
                    end
                endcase
            end
            S_SEED: begin
                n_h     = MUR_SEED ^ r_mres;
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_mstep = 2'd0;
                n_state = S_MUL;
                if (!r_last || (c_tail == 3'd0 && r_len != 16'd0)) begin
                    n_ma  = r_word;
                    n_ret = S_K1;
                end else if (c_tail != 3'd0) begin
                    n_ma  = r_h ^ (r_word & c_mask);
                    n_ret = S_HDONE;
                end else begin
                    n_ma  = r_h ^ (r_h >> MUR_SHIFT);
                    n_ret = S_F2;
                end
            end
            S_K1: begin
                n_ma    = c_k1;
                n_mstep = 2'd0;
                n_ret   = S_K2;
                n_state = S_MUL;
            end
            S_K2: begin
                n_ma    = r_h ^ r_mres;
                n_mstep = 2'd0;
                n_ret   = S_HDONE;
                n_state = S_MUL;
            end
            S_HDONE: begin
                if (!r_last) begin
                    n_acc   = r_mres;
                    n_kip   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ma    = c_k1;
                    n_mstep = 2'd0;
                    n_ret   = S_F2;
                    n_state = S_MUL;
                end
            end
            S_F2: begin
                n_h     = c_k1;
                n_state = S_RANK_RD;
            end
            S_RANK_RD: begin
                ram_raddr = r_h[63 -: PRECISION];
                n_rank    = c_rank;
                n_state   = S_RANK_WR;
            end
            S_RANK_WR: begin
                ram_waddr = r_h[63 -: PRECISION];
                ram_wdata = r_rank;
                ram_we    = (r_rank > ram_rdata);
                n_acc     = 64'd0;
                n_kip     = 1'b0;
                n_state   = S_IDLE;
            end
            // Read data returns in the cycle after the address, hence the valid flag.
            S_SUM: begin
                if (!r_addr[CW-1]) begin
                    n_addr = r_addr + 1'b1;
                end
                n_rdv = ~r_addr[CW-1];
                if (r_rdv) begin
                    n_z = r_z + c_zadd;
                    if (ram_rdata == '0) begin
                        n_empt = r_empt + 1'b1;
                    end
                end
                if (r_addr[CW-1] && !r_rdv) begin
                    n_rem   = '0;
                    n_q     = '0;
                    n_num   = DIV_NUM;
                    n_cnt   = 7'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_num = r_num << 1;
                n_cnt = r_cnt + 1'b1;
                if (c_rem2 >= {1'b0, r_z}) begin
                    n_rem = ZW'(c_rem2 - {1'b0, r_z});
                    n_q   = {r_q[126:0], 1'b1};
                end else begin
                    n_rem = c_rem2[ZW-1:0];
                    n_q   = {r_q[126:0], 1'b0};
                end
                if (r_cnt == 7'd127) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (c_lin) begin
                    n_k     = c_k;
                    n_y     = 32'(r_empt) << (5'd31 - 5'(c_k));
                    n_frac  = 32'd0;
                    n_cnt   = 7'd0;
                    n_state = S_LOG_SQ;
                end else begin
                    n_res.estimate = (r_q[127:48] != '0) ? EST_MAX : r_q[47:0];
                    n_res.used_linear_count = 1'b0;
                    n_state = S_EMIT;
                end
                n_res.empty_count = 11'(r_empt);
            end
            S_LOG_SQ: begin
                c_ma    = r_y;
                c_mb    = r_y;
                n_state = S_LOG_UPD;
            end
            S_LOG_UPD: begin
                n_frac = {r_frac[30:0], c_t[32]};
                n_y    = c_t[32] ? c_t[32:1] : c_t[31:0];
                n_cnt  = r_cnt + 1'b1;
                n_state = (r_cnt == 7'd31) ? S_LN_A : S_LOG_SQ;
            end
            S_LN_A: begin
                c_ma    = c_lq[31:0];
                c_mb    = LN2_Q32;
                n_state = S_LN_B;
            end
            S_LN_B: begin
                n_pa    = mul_p;
                c_ma    = 32'(c_lq[LQW-1:32]);
                c_mb    = LN2_Q32;
                n_state = S_LN_C;
            end
            S_LN_C: begin
                n_res.estimate = (c_est > 65'(EST_MAX)) ? EST_MAX : c_est[47:0];
                n_res.used_linear_count = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= S_IDLE;
            r_mstep     <= 2'd0;
            r_addr      <= '0;
            r_rdv       <= 1'b0;
            r_kip       <= 1'b0;
            r_acc       <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_mstep     <= n_mstep;
            r_addr      <= n_addr;
            r_rdv       <= n_rdv;
            r_kip       <= n_kip;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
        r_ma   <= n_ma;    r_p0   <= n_p0;    r_mres <= n_mres;  r_psum <= n_psum;
        r_word <= n_word;  r_len  <= n_len;   r_last <= n_last;  r_h    <= n_h;
        r_empt <= n_empt;  r_z    <= n_z;     r_rem  <= n_rem;   r_q    <= n_q;
        r_num  <= n_num;   r_cnt  <= n_cnt;   r_y    <= n_y;     r_frac <= n_frac;
        r_k    <= n_k;     r_pa   <= n_pa;    r_rank <= n_rank;  r_out  <= n_out;
        r_res  <= n_res;
    end
endmodule

[dv/hll_cardinality_estimator_core_tb.sv]
`timescale 1ns / 1ps

module hll_cardinality_estimator_core_tb;
    import hll_pkg::*;

    localparam int RANDOM_ITEMS = 1620;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic i_clk;
    logic i_rst_n;

    hll_in_if  in_ch ();
    hll_out_if out_ch ();

    hll_cardinality_estimator_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Predictor state: a private copy of the sketch.
    logic [6:0]  rank_mem [M_REGS];
    logic [63:0] run_hash;
    logic        mid_key;

    t_in_item  pending_items [$];
    t_out_item expected_estimates [$];
    int        errors;
    longint    cycle_count;

    function automatic logic [63:0] mix_word(logic [63:0] h, logic [63:0] k);
        k = k * MUR_MUL;
        k = k ^ (k >> MUR_SHIFT);
        k = k * MUR_MUL;
        h = h ^ k;
        return h * MUR_MUL;
    endfunction

    function automatic int count_lead_zeros(logic [63:0] w);
        int n;
        n = 0;
        while (n < 64 && !w[63-n]) n++;
        return n;
    endfunction

    function automatic logic [63:0] log2_fixed(logic [63:0] v);
        int k;
        logic [63:0] y;
        logic [63:0] frac;
        k = 63 - count_lead_zeros(v);
        y = (k <= 31) ? (v << (31 - k)) : (v >> (k - 31));
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                y = y >> 1;
            end
        end
        return (64'(k) << 32) | frac;
    endfunction

    function automatic t_out_item sketch_estimate();
        t_out_item res;
        logic [127:0] z;
        logic [127:0] q;
        logic [63:0] empties;
        logic [63:0] lg;
        logic [63:0] lq;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] est;
        logic [63:0] p32;
        int r;
        z = 0;
        empties = 0;
        for (int j = 0; j < M_REGS; j++) begin
            r = int'(rank_mem[j]);
            if (r == 0) begin
                empties++;
                z = z + (128'd1 << 64);
            end else begin
                if (r > 64) r = 64;
                z = z + (128'd1 << (64 - r));
            end
        end
        q = ({64'd0, ALPHA_Q32 * M64 * M64} << 40) / z;
        res.used_linear_count = 1'b0;
        if (empties > 0 && q <= 128'(640 * M_REGS)) begin
            lg = log2_fixed(empties);
            p32 = 64'(PRECISION) << 32;
            lq = (lg > p32) ? 64'd0 : p32 - lg;
            a = {32'd0, lq[31:0]} * {32'd0, LN2_Q32};
            b = (lq >> 32) * {32'd0, LN2_Q32};
            est = (b + (a >> 32)) >> EST_SHIFT;
            if (est > {16'd0, EST_MAX}) est = {16'd0, EST_MAX};
            res.used_linear_count = 1'b1;
        end else begin
            est = (q > {80'd0, EST_MAX}) ? {16'd0, EST_MAX} : q[63:0];
        end
        res.estimate = est[47:0];
        res.empty_count = empties[10:0];
        return res;
    endfunction

    task automatic predict_item(t_in_item it);
        logic [63:0] h;
        logic [63:0] w;
        int t;
        int idx;
        int rk;
        if (it.func == FUNC_ESTIMATE) begin
            expected_estimates.push_back(sketch_estimate());
            return;
        end
        h = mid_key ? run_hash : (MUR_SEED ^ ({48'd0, it.key_length} * MUR_MUL));
        if (!it.last_word) begin
            run_hash = mix_word(h, it.key_word);
            mid_key = 1'b1;
            return;
        end
        t = int'(it.key_length[2:0]);
        if (t != 0) begin
            h = h ^ (it.key_word & ((64'd1 << (8 * t)) - 1));
            h = h * MUR_MUL;
        end else if (it.key_length != 0) begin
            h = mix_word(h, it.key_word);
        end
        h = h ^ (h >> MUR_SHIFT);
        h = h * MUR_MUL;
        h = h ^ (h >> MUR_SHIFT);
        idx = int'(h[63 -: PRECISION]);
        w = h << PRECISION;
        rk = (w == 0) ? 64 : count_lead_zeros(w) + 1;
        if (rk > rank_mem[idx]) rank_mem[idx] = 7'(rk);
        run_hash = 0;
        mid_key = 1'b0;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_item(logic func, logic [63:0] wd, logic [15:0] len, logic last);
        t_in_item it;
        it.func = func;
        it.key_word = wd;
        it.key_length = len;
        it.last_word = last;
        pending_items.push_back(it);
    endtask

    // A well-formed key: one word per eight bytes, the length on every word.
    task automatic queue_key(int len);
        int words;
        words = (len == 0) ? 1 : (len + 7) / 8;
        for (int i = 0; i < words; i++)
            queue_item(FUNC_KEY, rand_word(), 16'(len), i == words - 1);
    endtask

    // Sender: bursts of random length separated by random gaps.
    // The head of the queue is the item on the bus while valid is high.
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_item(in_ch.data);
                void'(pending_items.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the item until the transfer.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_items[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls on a pattern whose mode is drawn anew at random.
    int stall_mode;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_mode   <= 0;
        end else begin
            if (cycle_count % 500 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= ($urandom_range(0, 9) == 0);
                default: out_ch.ready <= (cycle_count % 37) > 20;
            endcase
            if (out_ch.valid && out_ch.ready) begin
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected estimate, actual %h", $time, out_ch.data);
                    errors++;
                end else begin
                    t_out_item exp_item;
                    exp_item = expected_estimates.pop_front();
                    if (exp_item.estimate !== out_ch.data.estimate) begin
                        $display("%0t: estimate expected %h actual %h", $time,
                                 exp_item.estimate, out_ch.data.estimate);
                        errors++;
                    end
                    if (exp_item.used_linear_count !== out_ch.data.used_linear_count) begin
                        $display("%0t: used_linear_count expected %b actual %b", $time,
                                 exp_item.used_linear_count, out_ch.data.used_linear_count);
                        errors++;
                    end
                    if (exp_item.empty_count !== out_ch.data.empty_count) begin
                        $display("%0t: empty_count expected %0d actual %0d", $time,
                                 exp_item.empty_count, out_ch.data.empty_count);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int kind;
        int len;
        errors = 0;
        cycle_count = 0;
        mid_key = 1'b0;
        run_hash = 0;
        for (int j = 0; j < M_REGS; j++) rank_mem[j] = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;

        // Directed: empty sketch, empty key, every tail size, all-ones and zero words.
        queue_item(FUNC_ESTIMATE, 64'd0, 16'd0, 1'b0);
        queue_item(FUNC_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1'b1);
        for (int t = 1; t <= 8; t++) queue_key(t);
        queue_item(FUNC_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        queue_item(FUNC_KEY, 64'd0, 16'd16, 1'b0);
        // Estimate in the middle of a key; the key then goes on.
        queue_item(FUNC_ESTIMATE, rand_word(), 16'hFFFF, 1'b1);
        queue_item(FUNC_KEY, 64'd0, 16'd16, 1'b1);
        // Word count and length disagree, length changes on the last word.
        queue_item(FUNC_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 16'd3, 1'b0);
        queue_item(FUNC_KEY, 64'hFFFF_FFFF_FFFF_FFFF, 16'd8, 1'b0);
        queue_item(FUNC_KEY, rand_word(), 16'd0, 1'b1);
        queue_key(20);
        queue_item(FUNC_ESTIMATE, 64'd0, 16'd0, 1'b0);

        // Random: mostly well-formed keys, some noise, estimates now and then.
        for (int n = 0; n < RANDOM_ITEMS; ) begin
            kind = $urandom_range(0, 99);
            if (kind < 4) begin
                queue_item(FUNC_ESTIMATE, rand_word(), 16'($urandom()), 1'($urandom()));
                n++;
            end else if (kind < 14) begin
                queue_item(FUNC_KEY, rand_word(), 16'($urandom()), 1'($urandom()));
                n++;
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
                queue_key(len);
                n += (len == 0) ? 1 : (len + 7) / 8;
            end
        end
        queue_item(FUNC_ESTIMATE, 64'd0, 16'd0, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !(in_ch.valid && !in_ch.ready));
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (errors == 0 && expected_estimates.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
